FILE: src/euler_scale_translate_matrix_assert.svh
// ============================================================================
// Assertion macros for the Euler scale/translate matrix block
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef EULER_SCALE_TRANSLATE_MATRIX_ASSERT_SVH
`define EULER_SCALE_TRANSLATE_MATRIX_ASSERT_SVH

`ifndef SYNTHESIS
`define ESTM_ASSERT_IMPLY(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define ESTM_ASSERT_DELAY(label, cond, n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> ##n (prop)) \
        else $error("assertion failed");
`else
`define ESTM_ASSERT_IMPLY(label, cond, prop)
`define ESTM_ASSERT_DELAY(label, cond, n, prop)
`endif

`endif

FILE: src/estm_pkg.sv
// ============================================================================
// estm_pkg
// Word types and the shared constant of the Euler scale/translate matrix block.
// ============================================================================
package estm_pkg;

    localparam int ONE_Q14_SHIFT = 14;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] scale_z;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
    } item_t;

    typedef struct packed {
        logic signed [15:0] xbasis_x;
        logic signed [15:0] xbasis_y;
        logic signed [15:0] xbasis_z;
        logic signed [15:0] ybasis_x;
        logic signed [15:0] ybasis_y;
        logic signed [15:0] ybasis_z;
        logic signed [15:0] zbasis_x;
        logic signed [15:0] zbasis_y;
        logic signed [15:0] zbasis_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } result_t;

    // Sine and cosine of the three angles, signed Q1.14.
    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] cx;
        logic signed [15:0] sy;
        logic signed [15:0] cy;
        logic signed [15:0] sz;
        logic signed [15:0] cz;
    } trig_t;

endpackage

FILE: src/estm_trig.sv
// ============================================================================
// estm_trig
// Two-stage sine/cosine lookup of three binary angles from a quarter-wave
// table in Q1.14. Stage one folds quadrants into table indexes, stage two
// reads the table and applies the sign.
// ============================================================================
module estm_trig #(
    parameter int ANGLE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 enable,
    input  logic signed [15:0]   angle_x,
    input  logic signed [15:0]   angle_y,
    input  logic signed [15:0]   angle_z,
    output logic                 trig_valid,
    output estm_pkg::trig_t      trig
);

    localparam int QS = ANGLE_BITS - 2;
    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = QS + IW;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [14:0] tbl_t [0:SINE_TABLE_DEPTH];

    // The table is defined by a truncated nine-term Taylor series in Q30.
    function automatic tbl_t build_tbl();
        tbl_t               t;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            x    = 64'(i) * HALF_PI_Q30 / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
            if (sum < 0)
            begin
                sum = 0;
            end
            sum = (sum + 64'sd32768) >>> 16;
            if (sum > 64'sd16384)
            begin
                sum = 64'sd16384;
            end
            t[i] = 15'(sum);
        end
        return t;
    endfunction

    localparam tbl_t SINE_TBL = build_tbl();

    logic [ANGLE_BITS-1:0] ang [3];
    logic [IW-1:0]         idx_s_next [3];
    logic [IW-1:0]         idx_c_next [3];
    logic                  neg_s_next [3];
    logic                  neg_c_next [3];
    logic [IW-1:0]         idx_s_reg  [3];
    logic [IW-1:0]         idx_c_reg  [3];
    logic                  neg_s_reg  [3];
    logic                  neg_c_reg  [3];
    logic                  a_valid_reg;
    logic signed [15:0]    val_s [3];
    logic signed [15:0]    val_c [3];
    estm_pkg::trig_t       trig_next;
    estm_pkg::trig_t       trig_reg;
    logic                  b_valid_reg;

    always_comb
    begin
        logic [1:0]    quad;
        logic [1:0]    cquad;
        logic [PW-1:0] prod;
        logic [IW-1:0] idx;
        ang[0] = ANGLE_BITS'(angle_x);
        ang[1] = ANGLE_BITS'(angle_y);
        ang[2] = ANGLE_BITS'(angle_z);
        for (int a = 0; a < 3; a++)
        begin
            quad  = ang[a][ANGLE_BITS-1 -: 2];
            cquad = quad + 2'd1;
            prod  = PW'(ang[a][QS-1:0]) * PW'(SINE_TABLE_DEPTH) + (PW'(1) << (QS - 1));
            idx   = IW'(prod >> QS);
            // Odd quadrants run the table backward; cosine is one quadrant ahead.
            idx_s_next[a] = quad[0]  ? IW'(SINE_TABLE_DEPTH) - idx : idx;
            idx_c_next[a] = cquad[0] ? IW'(SINE_TABLE_DEPTH) - idx : idx;
            neg_s_next[a] = quad[1];
            neg_c_next[a] = cquad[1];
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            val_s[a] = neg_s_reg[a] ? -$signed({1'b0, SINE_TBL[idx_s_reg[a]]})
                                    :  $signed({1'b0, SINE_TBL[idx_s_reg[a]]});
            val_c[a] = neg_c_reg[a] ? -$signed({1'b0, SINE_TBL[idx_c_reg[a]]})
                                    :  $signed({1'b0, SINE_TBL[idx_c_reg[a]]});
        end
        trig_next.sx = val_s[0];
        trig_next.cx = val_c[0];
        trig_next.sy = val_s[1];
        trig_next.cy = val_c[1];
        trig_next.sz = val_s[2];
        trig_next.cz = val_c[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= enable;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            idx_s_reg[a] <= idx_s_next[a];
            idx_c_reg[a] <= idx_c_next[a];
            neg_s_reg[a] <= neg_s_next[a];
            neg_c_reg[a] <= neg_c_next[a];
        end
        trig_reg <= trig_next;
    end

    assign trig_valid = b_valid_reg;
    assign trig       = trig_reg;

endmodule

FILE: src/euler_scale_translate_matrix.sv
// ============================================================================
// euler_scale_translate_matrix
// Throughput: one word per cycle; busy is always low. Each accepted word comes
// out on result with done high.
// The six register stages are angle folding (loaded at the accept edge), table
// read, trig pair products, the Q42 combinations, the scale multiply, and
// round/saturate.
// Reset clears only the valid bits of the stages.
// ============================================================================
`include "euler_scale_translate_matrix_assert.svh"

module euler_scale_translate_matrix #(
    parameter int ANGLE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  estm_pkg::item_t     item,
    output logic                busy,
    output logic                done,
    output estm_pkg::result_t   result
);

    localparam int K = estm_pkg::ONE_Q14_SHIFT;

    logic               accept;
    logic               trig_valid;
    estm_pkg::trig_t    trig;
    estm_pkg::item_t    d1_reg;
    estm_pkg::item_t    d2_reg;

    // Stage three: pair products, Q28.
    logic signed [30:0] czcy_reg, cysz_reg, czsy_reg, czcx_reg, szsy_reg;
    logic signed [30:0] cysx_reg, szsx_reg, cxsz_reg, czsx_reg, cycx_reg;
    logic signed [15:0] sx_reg, sy_reg;
    estm_pkg::item_t    d3_reg;
    logic               v3_reg;

    // Stage four: trig combinations, Q42.
    logic signed [45:0] comb_next [9];
    logic signed [45:0] comb_reg  [9];
    estm_pkg::item_t    d4_reg;
    logic               v4_reg;

    // Stage five: scaled products, Q50.
    logic signed [61:0] prod_next [9];
    logic signed [61:0] prod_reg  [9];
    logic signed [15:0] scl [9];
    estm_pkg::item_t    d5_reg;
    logic               v5_reg;

    logic signed [15:0] basis_next [9];
    estm_pkg::result_t  result_next;
    estm_pkg::result_t  result_reg;
    logic               done_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    estm_trig #(
        .ANGLE_BITS       (ANGLE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_trig (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (accept),
        .angle_x    (item.angle_x),
        .angle_y    (item.angle_y),
        .angle_z    (item.angle_z),
        .trig_valid (trig_valid),
        .trig       (trig)
    );

    always_comb
    begin
        comb_next[0] = 46'(czcy_reg) <<< K;
        comb_next[1] = 46'(cysz_reg) <<< K;
        comb_next[2] = -(46'(sy_reg) <<< (2 * K));
        comb_next[3] = 46'(czsy_reg) * 46'(sx_reg) - (46'(cysz_reg) <<< K);
        comb_next[4] = (46'(czcx_reg) <<< K) + 46'(szsy_reg) * 46'(sx_reg);
        comb_next[5] = 46'(cysx_reg) <<< K;
        comb_next[6] = (46'(szsx_reg) <<< K) + 46'(czcx_reg) * 46'(sy_reg);
        comb_next[7] = 46'(cxsz_reg) * 46'(sy_reg) - (46'(czsx_reg) <<< K);
        comb_next[8] = 46'(cycx_reg) <<< K;
    end

    always_comb
    begin
        scl[0] = d4_reg.scale_x;
        scl[1] = d4_reg.scale_x;
        scl[2] = d4_reg.scale_x;
        scl[3] = d4_reg.scale_y;
        scl[4] = d4_reg.scale_y;
        scl[5] = d4_reg.scale_y;
        scl[6] = d4_reg.scale_z;
        scl[7] = d4_reg.scale_z;
        scl[8] = d4_reg.scale_z;
        for (int i = 0; i < 9; i++)
        begin
            prod_next[i] = 62'(scl[i]) * 62'(comb_reg[i]);
        end
    end

    // Round half up from Q50 to Q8.8 and saturate.
    always_comb
    begin
        logic signed [61:0] r;
        for (int i = 0; i < 9; i++)
        begin
            r = (prod_reg[i] + (62'sd1 <<< 41)) >>> 42;
            if (r > 62'sd32767)
            begin
                basis_next[i] = 16'sh7fff;
            end
            else if (r < -62'sd32768)
            begin
                basis_next[i] = -16'sh8000;
            end
            else
            begin
                basis_next[i] = 16'(r);
            end
        end
        result_next.xbasis_x = basis_next[0];
        result_next.xbasis_y = basis_next[1];
        result_next.xbasis_z = basis_next[2];
        result_next.ybasis_x = basis_next[3];
        result_next.ybasis_y = basis_next[4];
        result_next.ybasis_z = basis_next[5];
        result_next.zbasis_x = basis_next[6];
        result_next.zbasis_y = basis_next[7];
        result_next.zbasis_z = basis_next[8];
        result_next.pos_x    = d5_reg.offset_x;
        result_next.pos_y    = d5_reg.offset_y;
        result_next.pos_z    = d5_reg.offset_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v3_reg   <= trig_valid;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_reg   <= item;
        d2_reg   <= d1_reg;
        d3_reg   <= d2_reg;
        d4_reg   <= d3_reg;
        d5_reg   <= d4_reg;
        czcy_reg <= 31'(trig.cz) * 31'(trig.cy);
        cysz_reg <= 31'(trig.cy) * 31'(trig.sz);
        czsy_reg <= 31'(trig.cz) * 31'(trig.sy);
        czcx_reg <= 31'(trig.cz) * 31'(trig.cx);
        szsy_reg <= 31'(trig.sz) * 31'(trig.sy);
        cysx_reg <= 31'(trig.cy) * 31'(trig.sx);
        szsx_reg <= 31'(trig.sz) * 31'(trig.sx);
        cxsz_reg <= 31'(trig.cx) * 31'(trig.sz);
        czsx_reg <= 31'(trig.cz) * 31'(trig.sx);
        cycx_reg <= 31'(trig.cy) * 31'(trig.cx);
        sx_reg   <= trig.sx;
        sy_reg   <= trig.sy;
        for (int i = 0; i < 9; i++)
        begin
            comb_reg[i] <= comb_next[i];
            prod_reg[i] <= prod_next[i];
        end
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ESTM_ASSERT_DELAY(a_start_gives_done, start, 6, done)
    `ESTM_ASSERT_IMPLY(a_done_has_start, done, $past(start, 6))
    `ESTM_ASSERT_IMPLY(a_pos_passes, done, result.pos_x == $past(item.offset_x, 6))

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler scale/translate matrix testbench
// Drives Euler angles, scales and offsets into the block and checks every
// scaled rotation basis and translation word against a built-in predictor.
// ----------------------------------------------------------------------------

class matrix_scoreboard;
    estm_pkg::result_t expected_q[$];
    int unsigned       mismatches;
    longint            sine_q14[0:1024];

    function new();
        longint unsigned x, x2, term;
        longint          sum;
        mismatches = 0;
        // Quarter-wave table: Taylor series in Q30, rounded half up to Q14.
        for (int i = 0; i <= 1024; i++)
        begin
            x = longint'(i) * 64'd1686629713 / 64'd1024;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int k = 1; k <= 8; k++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    sum -= longint'(term);
                else
                    sum += longint'(term);
            end
            if (sum < 0)
                sum = 0;
            sum = (sum + 32768) >>> 16;
            if (sum > 16384)
                sum = 16384;
            sine_q14[i] = sum;
        end
    endfunction

    function longint angle_sine(logic [15:0] a);
        logic [1:0]  quad;
        logic [13:0] p;
        int          idx;
        longint      v;
        quad = a[15:14];
        p = a[13:0];
        idx = (int'(p) * 1024 + 8192) >> 14;
        v = quad[0] ? sine_q14[1024 - idx] : sine_q14[idx];
        return quad[1] ? -v : v;
    endfunction

    function longint angle_cosine(logic [15:0] a);
        return angle_sine(a + 16'd16384);
    endfunction

    // Q8.8 scale times a Q42 combination, rounded half up and saturated.
    function logic signed [15:0] scale_round(logic signed [15:0] s, longint comb);
        longint r;
        r = (longint'(s) * comb + (longint'(1) << 41)) >>> 42;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    function void note_word(estm_pkg::item_t w);
        estm_pkg::result_t r;
        longint sx, cx, sy, cy, sz, cz, k;
        sx = angle_sine(w.angle_x);
        cx = angle_cosine(w.angle_x);
        sy = angle_sine(w.angle_y);
        cy = angle_cosine(w.angle_y);
        sz = angle_sine(w.angle_z);
        cz = angle_cosine(w.angle_z);
        k = 16384;
        r.xbasis_x = scale_round(w.scale_x, cz * cy * k);
        r.xbasis_y = scale_round(w.scale_x, cy * sz * k);
        r.xbasis_z = scale_round(w.scale_x, -sy * k * k);
        r.ybasis_x = scale_round(w.scale_y, cz * sy * sx - cy * sz * k);
        r.ybasis_y = scale_round(w.scale_y, cz * cx * k + sz * sy * sx);
        r.ybasis_z = scale_round(w.scale_y, cy * sx * k);
        r.zbasis_x = scale_round(w.scale_z, sz * sx * k + cz * cx * sy);
        r.zbasis_y = scale_round(w.scale_z, cx * sz * sy - cz * sx * k);
        r.zbasis_z = scale_round(w.scale_z, cy * cx * k);
        r.pos_x = w.offset_x;
        r.pos_y = w.offset_y;
        r.pos_z = w.offset_z;
        expected_q.push_back(r);
    endfunction

    function void compare_field(string name, longint e, longint a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
            mismatches++;
        end
    endfunction

    function void check_word(estm_pkg::result_t a);
        estm_pkg::result_t e;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result word %h", $time, a);
            mismatches++;
            return;
        end
        e = expected_q.pop_front();
        compare_field("xbasis_x", e.xbasis_x, a.xbasis_x);
        compare_field("xbasis_y", e.xbasis_y, a.xbasis_y);
        compare_field("xbasis_z", e.xbasis_z, a.xbasis_z);
        compare_field("ybasis_x", e.ybasis_x, a.ybasis_x);
        compare_field("ybasis_y", e.ybasis_y, a.ybasis_y);
        compare_field("ybasis_z", e.ybasis_z, a.ybasis_z);
        compare_field("zbasis_x", e.zbasis_x, a.zbasis_x);
        compare_field("zbasis_y", e.zbasis_y, a.zbasis_y);
        compare_field("zbasis_z", e.zbasis_z, a.zbasis_z);
        compare_field("pos_x", e.pos_x, a.pos_x);
        compare_field("pos_y", e.pos_y, a.pos_y);
        compare_field("pos_z", e.pos_z, a.pos_z);
    endfunction
endclass

module tb;
    logic              clk;
    logic              rst_n;
    logic              start;
    estm_pkg::item_t   item;
    logic              busy;
    logic              done;
    estm_pkg::result_t result;

    matrix_scoreboard matrix_sb;
    int unsigned      cycle_count;
    bit               gaps_on;

    euler_scale_translate_matrix i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        matrix_sb = new();
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && start && !busy)
            matrix_sb.note_word(item);
        if (rst_n && done)
            matrix_sb.check_word(result);
    end

    initial
    begin
        cycle_count = 0;
        wait (cycle_count >= 400000);
        $display("TB_ERROR");
        $finish;
    end

    // Holds start high with the given word until the block takes it.
    task automatic send_word(estm_pkg::item_t w);
        bit taken;
        start <= 1'b1;
        item <= w;
        forever
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
            if (taken)
                break;
        end
    endtask

    task automatic maybe_gap();
        int n;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 17);
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
            1: return 16'($urandom_range(0, 7) * 8192);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 512) - 256);
            1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic estm_pkg::item_t make_word(logic [15:0] a, logic [15:0] s,
                                                  logic [31:0] o);
        estm_pkg::item_t w;
        w.angle_x = a;
        w.angle_y = a ^ 16'h4000;
        w.angle_z = -a;
        w.scale_x = s;
        w.scale_y = -s;
        w.scale_z = s ^ 16'h00ff;
        w.offset_x = o;
        w.offset_y = ~o;
        w.offset_z = o ^ 32'h5555_aaaa;
        return w;
    endfunction

    initial
    begin
        estm_pkg::item_t w;
        logic [15:0] dir_angles [0:6] = '{16'h0000, 16'h4000, 16'h8000, 16'h7fff,
                                          16'hc000, 16'h2000, 16'h0001};
        logic [15:0] dir_scales [0:6] = '{16'h7fff, 16'h8000, 16'h0000, 16'h0100,
                                          16'hff00, 16'h0001, 16'hffff};
        logic [31:0] dir_offsets [0:2] = '{32'h7fffffff, 32'h80000000, 32'h0};

        gaps_on = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes of angles, scales and offsets, including full-scale saturation.
        for (int i = 0; i < 7; i++)
            for (int j = 0; j < 3; j++)
                send_word(make_word(dir_angles[i], dir_scales[(i + j * 3) % 7],
                                    dir_offsets[j]));
        start <= 1'b0;
        while (matrix_sb.expected_q.size() != 0)
            @(posedge clk);

        gaps_on = 1'b1;
        for (int n = 0; n < 1630; n++)
        begin
            w.angle_x = pick_angle();
            w.angle_y = pick_angle();
            w.angle_z = pick_angle();
            w.scale_x = pick_scale();
            w.scale_y = pick_scale();
            w.scale_z = pick_scale();
            w.offset_x = $urandom;
            w.offset_y = $urandom;
            w.offset_z = $urandom;
            send_word(w);
            if (n == 700)
            begin
                // Let the pipeline drain completely before going on.
                start <= 1'b0;
                while (matrix_sb.expected_q.size() != 0)
                    @(posedge clk);
            end
            else if (n == 1400)
                gaps_on = 1'b0;
            else
                maybe_gap();
        end
        start <= 1'b0;

        while (matrix_sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (matrix_sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

FILE: euler_scale_translate_matrix.f
+incdir+src
src/estm_pkg.sv
src/estm_trig.sv
src/euler_scale_translate_matrix.sv
tb/sv/tb.sv
